// ===== rtl/core/double_ended_queue_assert.svh =====
// Assertion macros for the deque block.
// Each macro samples on the rising edge of clk and stays quiet while arst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int DQ_DEPTH = 64;
	localparam int VAL_W    = 32;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation applied to one storage cell in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHR   = 2'd1,
		CELL_SHL   = 2'd2,
		CELL_LOAD  = 2'd3
	} cell_op_t;

	// Control for one row of cells.
	typedef struct packed {
		logic shift_in;
		logic shift_out;
		logic wr;
	} chain_ctrl_t;

	typedef struct packed {
		req_type_t req_type;
		val_t      push_value;
	} req_t;

	typedef struct packed {
		val_t       pop_value;
		status_t    status;
		logic [6:0] entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/dq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
	input  logic            clk,
	input  dq_pkg::cell_op_t op,
	input  dq_pkg::val_t     from_left,
	input  dq_pkg::val_t     from_right,
	input  dq_pkg::val_t     load_val,
	output dq_pkg::val_t     q
);
	import dq_pkg::*;

	val_t data_q;

	// Hold, take a neighbor's value or load a new one
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD: data_q <= data_q;
			CELL_SHR:  data_q <= from_left;
			CELL_SHL:  data_q <= from_right;
			CELL_LOAD: data_q <= load_val;
			default:   data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/dq_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_chain #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic               clk,
	input  dq_pkg::chain_ctrl_t ctrl,
	input  dq_pkg::val_t        din,
	input  logic [DEPTH-1:0]   wr_sel,
	output dq_pkg::val_t        head
);
	import dq_pkg::*;

	val_t cell_q [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			cell_op_t op;
			val_t     left_v;
			val_t     right_v;

			// Pick this cell's operation: shifts move the whole row, a write hits one cell
			always_comb begin
				priority if (ctrl.shift_in) begin
					op = CELL_SHR;
				end else if (ctrl.shift_out) begin
					op = CELL_SHL;
				end else if (ctrl.wr && wr_sel[i]) begin
					op = CELL_LOAD;
				end else begin
					op = CELL_HOLD;
				end
			end

			// Cell 0 takes the new value on a shift in; the last cell keeps its own
			if (i == 0) begin : g_first
				assign left_v = din;
			end else begin : g_mid_l
				assign left_v = cell_q[i-1];
			end
			if (i == DEPTH-1) begin : g_last
				assign right_v = cell_q[i];
			end else begin : g_mid_r
				assign right_v = cell_q[i+1];
			end

			dq_cell u_cell (
				.clk        (clk),
				.op         (op),
				.from_left  (left_v),
				.from_right (right_v),
				.load_val   (din),
				.q          (cell_q[i])
			);
		end
	endgenerate

	assign head = cell_q[0];

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Channel   Handshake            Payload   Direction
// request   start / busy         req       in
// result    done (one cycle)     rsp       out
//
// One request is taken every clock cycle; busy stays low.
// The result of a request appears in the cycle after it is taken, held for one cycle.
// Two rows of DEPTH cells store the queue front-first and back-first, so every
// pop reads cell 0 of one row and every push shifts one row and writes one cell of the other.
// Reset clears the count and the result strobe; cell contents are not reset.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dq_pkg::req_t req,
	output logic         done,
	output dq_pkg::rsp_t rsp
);
	import dq_pkg::*;

	`include "double_ended_queue_assert.svh"

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CWX = (CW > 7) ? CW : 7;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [CWX-1:0]   count_x;
	logic [DEPTH-1:0] wr_sel;
	logic             go;
	logic             full;
	logic             empty;
	logic             is_push;
	chain_ctrl_t      fwd_ctrl;
	chain_ctrl_t      rev_ctrl;
	val_t             fwd_head;
	val_t             rev_head;
	rsp_t             rsp_d;
	rsp_t             rsp_q;
	logic             done_q;

	assign busy    = 1'b0;
	assign go      = start && !busy;
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_PUSH_BACK);
	assign wr_sel  = {{(DEPTH-1){1'b0}}, 1'b1} << count_q;

	// Decode the request into row controls, the result and the next count
	always_comb begin
		fwd_ctrl          = '0;
		rev_ctrl          = '0;
		count_d           = count_q;
		rsp_d.pop_value   = '0;
		rsp_d.status      = ST_OK;
		unique case (req.req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					fwd_ctrl.shift_in = go;
					rev_ctrl.wr       = go;
					count_d           = count_q + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					rev_ctrl.shift_in = go;
					fwd_ctrl.wr       = go;
					count_d           = count_q + 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.pop_value    = fwd_head;
					fwd_ctrl.shift_out = go;
					count_d            = count_q - 1'b1;
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.pop_value    = rev_head;
					rev_ctrl.shift_out = go;
					count_d            = count_q - 1'b1;
				end
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
		count_x           = CWX'(count_d);
		rsp_d.entry_count = count_x[6:0];
	end

	// Row that holds the queue front-first
	dq_chain #(.DEPTH(DEPTH)) u_fwd (
		.clk    (clk),
		.ctrl   (fwd_ctrl),
		.din    (req.push_value),
		.wr_sel (wr_sel),
		.head   (fwd_head)
	);

	// Row that holds the queue back-first
	dq_chain #(.DEPTH(DEPTH)) u_rev (
		.clk    (clk),
		.ctrl   (rev_ctrl),
		.din    (req.push_value),
		.wr_sel (wr_sel),
		.head   (rev_head)
	);

	// Advance the count and raise the strobe on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= go;
			if (go) begin
				count_q <= count_d;
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`DEQ_ASSERT_NEXT(a_done_follows, go, done, "result strobe missing after a request")
	`DEQ_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`DEQ_ASSERT_NEXT(a_full_hold, go && is_push && full, $stable(count_q), "full push changed count")
	`DEQ_ASSERT_NEXT(a_pop_dec, go && !is_push && !empty, count_q == $past(count_q) - 1'b1, "pop did not decrement count")

endmodule

`default_nettype wire

// ===== tb/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker
	import dq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen,
	output int   full_rejects,
	output int   empty_pops
);

	localparam int IDX_W = $clog2(DQ_DEPTH);

	// Shadow copy of the deque: slots, front position and fill level
	val_t             shadow_slots [DQ_DEPTH];
	logic [IDX_W-1:0] shadow_front;
	logic [6:0]       shadow_level;

	// Responses still owed by the block, oldest first
	rsp_t expected_rsps [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] deque mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Apply one request to the shadow deque and return the response it should produce
	function automatic rsp_t apply_request(input req_t r);
		rsp_t             o;
		logic [IDX_W-1:0] pos;
		o.pop_value   = '0;
		o.status      = ST_OK;
		case (r.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (shadow_level == 7'(DQ_DEPTH)) begin
					o.status = ST_FULL;
				end else begin
					if (r.req_type == REQ_PUSH_FRONT) begin
						// grow the front downward, except into an empty deque
						if (shadow_level != 0)
							shadow_front = shadow_front - 1'b1;
						pos = shadow_front;
					end else begin
						pos = shadow_front + shadow_level[IDX_W-1:0];
					end
					shadow_slots[pos] = r.push_value;
					shadow_level++;
				end
			end
			default: begin
				if (shadow_level == 0) begin
					o.status = ST_EMPTY;
				end else if (r.req_type == REQ_POP_FRONT) begin
					o.pop_value = shadow_slots[shadow_front];
					shadow_level--;
					if (shadow_level != 0)
						shadow_front = shadow_front + 1'b1;
				end else begin
					pos = shadow_front + shadow_level[IDX_W-1:0] - 1'b1;
					o.pop_value = shadow_slots[pos];
					shadow_level--;
				end
			end
		endcase
		o.entry_count = shadow_level;
		return o;
	endfunction

	// Retire the response shown this cycle, then predict the transaction taken at this edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_front = '0;
			shadow_level = '0;
			expected_rsps.delete();
			outstanding  = 0;
			mismatches   = 0;
			results_seen = 0;
			full_rejects = 0;
			empty_pops   = 0;
		end else begin
			if (done === 1'b1) begin
				results_seen++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.pop_value !== want.pop_value)
						report_mismatch($sformatf("pop_value %0d, want %0d",
							rsp.pop_value, want.pop_value));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count %0d, want %0d",
							rsp.entry_count, want.entry_count));
					if (want.status == ST_FULL)
						full_rejects++;
					if (want.status == ST_EMPTY)
						empty_pops++;
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_rsps.push_back(apply_request(req));
			// Track how many responses are still owed
			outstanding = expected_rsps.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import dq_pkg::*;

	localparam int RANDOM_REQS = 900;
	localparam int IDLE_LIMIT  = 300;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	int   mismatches;
	int   outstanding;
	int   results_seen;
	int   full_rejects;
	int   empty_pops;
	logic busy_seen;
	int   idle_cycles;
	int   burst_left;

	double_ended_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	deque_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.done         (done),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.full_rejects (full_rejects),
		.empty_pops   (empty_pops)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// busy only moves on a rising edge, so its mid-cycle value decides the next edge
	always @(negedge clk) begin
		busy_seen <= busy;
	end

	// Abort if no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Hold the request until the block takes it
	task automatic issue(input req_type_t kind, input val_t value);
		start          <= 1'b1;
		req.req_type   <= kind;
		req.push_value <= value;
		do
			@(posedge clk);
		while (busy_seen !== 1'b0);
	endtask

	// Close a burst with a random gap, or keep streaming
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	function automatic val_t pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return '1;
			default: return val_t'($urandom);
		endcase
	endfunction

	initial begin
		int        mode;
		int        mode_left;
		int        push_pct;
		req_type_t kind;
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		busy_seen   = 1'b0;
		idle_cycles = 0;
		burst_left  = 0;
		mode_left   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, pushes onto empty from both ends, extreme values
		issue(REQ_POP_FRONT, 32'sd5);
		issue(REQ_POP_BACK, 32'sd7);
		issue(REQ_PUSH_FRONT, 32'sh7fff_ffff);
		issue(REQ_POP_BACK, '0);
		issue(REQ_PUSH_BACK, 32'sh8000_0000);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_PUSH_FRONT, '1);
		issue(REQ_PUSH_BACK, '0);
		issue(REQ_PUSH_FRONT, 32'sd1);
		issue(REQ_PUSH_BACK, 32'sh5555_5555);
		issue(REQ_PUSH_FRONT, 32'shaaaa_aaaa);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_BACK, '0);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_BACK, '0);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_BACK, '0);
		issue(REQ_POP_FRONT, '0);
		start <= 1'b0;
		repeat (3) @(posedge clk);

		// Random: alternate fill, drain and mixed phases so full and empty recur
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			if ($urandom_range(0, 99) < push_pct)
				kind = ($urandom_range(0, 1) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				kind = ($urandom_range(0, 1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
			issue(kind, pick_value());
			pace();
		end
		start <= 1'b0;

		// Drain outstanding responses, then allow the pipeline to settle
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d responses: %0d rejected pushes on a full deque, %0d pops on empty",
			results_seen, full_rejects, empty_pops);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
